### rtl/utf8f_pkg.sv
// Package for the UTF-8 accent fold unit: decode modes, byte constants and the
// per-byte decision record passed from the fold logic to the top level.
// No dependencies.
package utf8f_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CHAR_W = 7;

   localparam logic [BYTE_W-1:0] BUFFER_SIZE_RESET = 8'd40;
   localparam logic [BYTE_W-1:0] LEAD_BYTE         = 8'hC3;
   localparam logic [BYTE_W-1:0] END_BYTE          = 8'h00;
   localparam logic [CHAR_W-1:0] UNKNOWN_CHAR      = 7'h3F;   // '?'
   localparam logic [CHAR_W-1:0] TERMINATOR_CHAR   = 7'h00;

   typedef enum logic [1:0] {
      MODE_NORMAL     = 2'd0,
      MODE_AFTER_LEAD = 2'd1,
      MODE_SKIP       = 2'd2
   } mode_type;

   typedef struct packed {
      logic              emit;
      logic [CHAR_W-1:0] out_byte;
      logic              end_of_string;
      mode_type          mode;
      logic [BYTE_W-1:0] chars;
   } step_type;

endpackage

### rtl/utf8f_req_if.sv
// Request channel of the UTF-8 accent fold unit: one input byte per request.
// Depends on utf8f_pkg.
interface utf8f_req_if;
   logic                           valid;
   logic                           ready;
   logic [utf8f_pkg::BYTE_W-1:0]   in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/utf8f_rsp_if.sv
// Response channel of the UTF-8 accent fold unit: one ASCII character per response.
// Depends on utf8f_pkg.
interface utf8f_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [utf8f_pkg::CHAR_W-1:0]   out_byte;
   logic                           end_of_string;

   modport source (output valid, output out_byte, output end_of_string, input ready);
   modport sink   (input valid, input out_byte, input end_of_string, output ready);
endinterface

### rtl/utf8f_csr_if.sv
// Register write channel of the UTF-8 accent fold unit: carries buffer_size.
// Depends on utf8f_pkg.
interface utf8f_csr_if;
   logic                           valid;
   logic                           ready;
   logic [utf8f_pkg::BYTE_W-1:0]   buffer_size;

   modport source (output valid, output buffer_size, input ready);
   modport sink   (input valid, input buffer_size, output ready);
endinterface

### rtl/utf8f_fold.sv
// Per-byte decode step: folds one byte against the current mode and fill count,
// giving the character to emit and the next state. Depends on utf8f_pkg.
module utf8f_fold (
   input  logic [utf8f_pkg::BYTE_W-1:0] in_byte,
   input  utf8f_pkg::mode_type          mode,
   input  logic [utf8f_pkg::BYTE_W-1:0] chars,
   input  logic [utf8f_pkg::BYTE_W-1:0] buffer_size,
   output utf8f_pkg::step_type          step
);
   import utf8f_pkg::*;

   function automatic logic [CHAR_W-1:0] fold_byte(input logic [BYTE_W-1:0] d);
      logic [CHAR_W-1:0] c;
      begin
         case (d) inside
            [8'h80:8'h85]: c = 7'h41;   // A
            [8'hA0:8'hA5]: c = 7'h61;   // a
            8'h87:         c = 7'h43;   // C
            8'hA7:         c = 7'h63;   // c
            [8'h88:8'h8B]: c = 7'h45;   // E
            [8'hA8:8'hAB]: c = 7'h65;   // e
            [8'h8C:8'h8F]: c = 7'h49;   // I
            [8'hAC:8'hAF]: c = 7'h69;   // i
            8'h91:         c = 7'h4E;   // N
            8'hB1:         c = 7'h6E;   // n
            [8'h92:8'h96]: c = 7'h4F;   // O
            [8'hB2:8'hB6]: c = 7'h6F;   // o
            [8'h99:8'h9C]: c = 7'h55;   // U
            [8'hB9:8'hBC]: c = 7'h75;   // u
            8'h9F:         c = 7'h73;   // s
            default:       c = UNKNOWN_CHAR;
         endcase
         return c;
      end
   endfunction

   logic [BYTE_W-1:0] chars_inc;
   logic              buffer_full;
   logic              is_continuation;

   assign chars_inc       = chars + 8'd1;
   // compare one bit wider so a count of 255 cannot wrap below the size
   assign buffer_full     = ({1'b0, chars} + 9'd1) >= {1'b0, buffer_size};
   assign is_continuation = (in_byte[7:6] == 2'b10);

   always_comb begin
      step.emit          = 1'b0;
      step.out_byte      = TERMINATOR_CHAR;
      step.end_of_string = 1'b0;
      step.mode          = mode;
      step.chars         = chars;

      if (in_byte == END_BYTE) begin
         step.emit          = 1'b1;
         step.end_of_string = 1'b1;
         step.mode          = MODE_NORMAL;
         step.chars         = '0;
      end else if (mode == MODE_AFTER_LEAD) begin
         // a pending lead byte completes whatever the fill level, unless it meets the end byte
         step.emit     = 1'b1;
         step.out_byte = fold_byte(in_byte);
         step.mode     = MODE_NORMAL;
         step.chars    = chars_inc;
      end else if (!(mode == MODE_SKIP && is_continuation)) begin
         // leave skip mode before the fill check
         if (mode == MODE_SKIP) begin
            step.mode = MODE_NORMAL;
         end
         if (!buffer_full) begin
            if (!in_byte[7]) begin
               step.emit     = 1'b1;
               step.out_byte = in_byte[CHAR_W-1:0];
               step.mode     = MODE_NORMAL;
               step.chars    = chars_inc;
            end else if (in_byte == LEAD_BYTE) begin
               step.mode = MODE_AFTER_LEAD;
            end else begin
               step.mode = MODE_SKIP;
            end
         end
      end
   end

endmodule

### rtl/utf8_accent_fold_to_ascii_unit.sv
// UTF-8 accent fold to ASCII: one byte per request, zero or one ASCII response.
// Data path: input register, fold logic, response register. Throughput: one
// request per cycle while responses are taken without stalls.
// Reset (synchronous, active high): decode mode normal, character count zero,
// buffer_size 40, pipeline empty.
// Depends on utf8f_pkg, the three channel interfaces and utf8f_fold.
module utf8_accent_fold_to_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   utf8f_req_if.sink   req_ch,
   utf8f_rsp_if.source rsp_ch,
   utf8f_csr_if.sink   csr_ch
);
   import utf8f_pkg::*;

   logic              stage_valid_ff, stage_valid_in;
   logic [BYTE_W-1:0] stage_byte_ff, stage_byte_in;
   mode_type          mode_ff, mode_in;
   logic [BYTE_W-1:0] chars_ff, chars_in;
   logic [BYTE_W-1:0] buffer_size_ff, buffer_size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_eos_ff, rsp_eos_in;

   logic              out_free;
   logic              advance;
   logic              req_take;
   step_type          step;

   utf8f_fold u_fold (
      .in_byte     (stage_byte_ff),
      .mode        (mode_ff),
      .chars       (chars_ff),
      .buffer_size (buffer_size_ff),
      .step        (step)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = stage_valid_ff && out_free;
   assign req_ch.ready = !stage_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_byte      = rsp_byte_ff;
   assign rsp_ch.end_of_string = rsp_eos_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_byte_in  = stage_byte_ff;
      mode_in        = mode_ff;
      chars_in       = chars_ff;
      buffer_size_in = buffer_size_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_eos_in     = rsp_eos_ff;

      if (csr_ch.valid) begin
         buffer_size_in = csr_ch.buffer_size;
      end

      // drop the response once taken; a new one may replace it below
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         mode_in        = step.mode;
         chars_in       = step.chars;
         rsp_valid_in   = step.emit;
         rsp_byte_in    = step.out_byte;
         rsp_eos_in     = step.end_of_string;
         stage_valid_in = 1'b0;
      end

      if (req_take) begin
         stage_valid_in = 1'b1;
         stage_byte_in  = req_ch.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         mode_ff        <= MODE_NORMAL;
         chars_ff       <= '0;
         buffer_size_ff <= BUFFER_SIZE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         mode_ff        <= mode_in;
         chars_ff       <= chars_in;
         buffer_size_ff <= buffer_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= stage_byte_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_eos_ff    <= rsp_eos_in;
   end

endmodule
